// ===== hw/rtl/i2f_pkg.sv =====
`timescale 1ns / 1ps
package i2f_pkg;
  localparam int unsigned ExpBias  = 127;
  localparam int unsigned FracBits = 23;
  localparam int unsigned DropBits = 9;
  localparam logic [8:0] HalfPoint = 9'h100;
endpackage

// ===== hw/rtl/int32_to_float32_convert.sv =====
`timescale 1ns / 1ps
// Signed 32-bit integer to IEEE-754 single conversion.
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// Stages: magnitude, leading-one count, normalizing shift, rounding.
// Reset (rst_ni low, asynchronous) clears all stage valid bits.
module int32_to_float32_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic signed [31:0] value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] float_bits_o
);

  logic adv;
  assign adv = !(valid_o && stall_i);
  assign stall_o = !adv;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        s1_q, s2_q, s3_q;
  logic [31:0] m1_q, m2_q;
  logic [4:0]  p2_q;
  logic        z2_q, z3_q;
  logic [7:0]  e3_q;
  logic [31:0] a3_q;
  logic [31:0] r4_q;

  logic [4:0]  p_d;
  always_comb begin
    p_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (m1_q[i]) p_d = 5'(i);
    end
  end

  logic [31:0] a_d;
  assign a_d = m2_q << (6'd32 - {1'b0, p2_q});

  logic [22:0] kept;
  logic [8:0]  tail;
  logic        rnd;
  logic [23:0] ksum;
  logic [7:0]  e_fin;
  logic [22:0] f_fin;
  assign kept = a3_q[31:i2f_pkg::DropBits];
  assign tail = a3_q[i2f_pkg::DropBits-1:0];
  assign rnd  = (tail > i2f_pkg::HalfPoint) ||
                ((tail == i2f_pkg::HalfPoint) && kept[0]);
  assign ksum = {1'b0, kept} + {23'd0, rnd};
  assign e_fin = ksum[23] ? e3_q + 8'd1 : e3_q;
  assign f_fin = ksum[23] ? '0 : ksum[22:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= value_i[31];
      m1_q <= value_i[31] ? 32'(-value_i) : value_i;
      s2_q <= s1_q;
      m2_q <= m1_q;
      p2_q <= p_d;
      z2_q <= (m1_q == '0);
      s3_q <= s2_q;
      z3_q <= z2_q;
      e3_q <= 8'({3'd0, p2_q} + 8'(i2f_pkg::ExpBias));
      a3_q <= (p2_q == '0) ? '0 : a_d;
      r4_q <= z3_q ? '0 : {s3_q, e_fin, f_fin};
    end
  end

  assign valid_o      = v4_q;
  assign float_bits_o = r4_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(float_bits_o))
    else $error("stalled result changed");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_o |=> v2_q == $past(v1_q))
    else $error("valid bit lost in pipe");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && z3_q && !stall_o |=> float_bits_o == '0)
    else $error("zero input not zero output");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic signed [31:0] value_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [31:0]        float_bits_o;

  logic [31:0] expected_floats[$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned received = 0;
  bit          stall_free = 1'b0;

  int32_to_float32_convert u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .float_bits_o(float_bits_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] int_to_single(logic [31:0] raw);
    logic        neg;
    logic [31:0] mag;
    logic [31:0] aligned;
    logic [31:0] kept;
    logic [8:0]  tail;
    logic [7:0]  expo;
    int          pos;
    neg = raw[31];
    mag = neg ? -raw : raw;
    if (mag == 0) return '0;
    pos = 0;
    for (int b = 0; b < 32; b++) if (mag[b]) pos = b;
    expo = 8'(pos + i2f_pkg::ExpBias);
    aligned = 32'(64'(mag) << (32 - pos));
    kept = aligned >> i2f_pkg::DropBits;
    tail = aligned[8:0];
    if (tail > i2f_pkg::HalfPoint || (tail == i2f_pkg::HalfPoint && aligned[9])) begin
      kept = kept + 32'd1;
    end
    if (kept[i2f_pkg::FracBits]) begin
      expo = expo + 8'd1;
      kept = '0;
    end
    return {neg, expo, kept[22:0]};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: float_bits got %h expected %h", what, got, want);
  endtask

  // result checker and random stall on the output side
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      received++;
      if (expected_floats.size() == 0) begin
        report("unexpected transaction", float_bits_o, 'x);
      end else begin
        logic [31:0] want;
        want = expected_floats.pop_front();
        if (float_bits_o !== want) report("transaction", float_bits_o, want);
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (stall_free || $urandom_range(0, 3) != 0) begin
        stall_i <= 1'b0;
      end else begin
        gap = $urandom_range(1, 12);
        stall_i <= 1'b1;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_value(logic [31:0] v, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    expected_floats.push_back(int_to_single(v));
    sent++;
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_special_values();
    logic [31:0] vals[$] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h8000_0001, 32'h0100_0000, 32'h0100_0001, 32'h0100_0003, 32'h0200_0002,
      32'h0100_0002, 32'h00FF_FFFF, 32'hFF00_0001, 32'h0000_0100, 32'h7FFF_FFC0,
      32'h7FFF_FF80, 32'h0080_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0003};
    foreach (vals[i]) send_value(vals[i], 1'b0);
    go_idle();
  endtask

  task automatic test_drain_pause();
    repeat (5) send_value($urandom, 1'b1);
    go_idle();
    while (expected_floats.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_random_values(int count);
    logic [31:0] v;
    int          shift;
    for (int i = 0; i < count; i++) begin
      v = $urandom;
      shift = $urandom_range(0, 31);
      case ($urandom_range(0, 3))
        0: v = v >> shift;
        1: v = -(v >> shift);
        2: v = (v & 32'hFFFF_FE00) | (($urandom_range(0, 1)) ? 32'h100 : 32'h0FF);
        default: ;
      endcase
      send_value(v, (i / 200) % 3 != 2);
    end
    go_idle();
  endtask

  task automatic test_back_to_back(int count);
    stall_free = 1'b1;
    for (int i = 0; i < count; i++) send_value($urandom, 1'b0);
    go_idle();
    stall_free = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_special_values();
    test_drain_pause();
    test_random_values(1600);
    test_back_to_back(225);
    while (expected_floats.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Converted %0d integers, checked %0d results: edge values, rounding ties,",
             sent, received);
    $display("random magnitudes under random input gaps and output stalls.");
    if (mismatches == 0 && expected_floats.size() == 0) begin
      $display("int32_to_float32_convert verification clean");
    end else begin
      $display("int32_to_float32_convert verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("int32_to_float32_convert verification failed");
    $finish;
  end
endmodule
